[src/particle_bounce_update_assert.svh]
// Assertion macros for the particle bounce update block.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef PARTICLE_BOUNCE_UPDATE_ASSERT_SVH
`define PARTICLE_BOUNCE_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold once the delay dly has passed after the antecedent.
`define PBU_ASSERT_LATER(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

[src/pbu_pkg.sv]
// Shared types, constants and helper functions of the particle bounce update block.
// No dependencies; every other file but the assertion header refers to it by scoped names.
package pbu_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACCEL_X   = 2'd0;
	localparam logic [1:0] REG_ACCEL_Y   = 2'd1;
	localparam logic [1:0] REG_TIME_STEP = 2'd2;

	localparam logic [11:0] TIME_STEP_RESET = 12'd123;

	// Q0.16 constants.
	localparam logic [15:0] K_DECAY = 16'd58982;
	localparam logic [13:0] K_GLOW  = 14'd9830;
	localparam logic [16:0] K_DAMP  = 17'd52429;

	// Box walls in Q3.12.
	localparam logic signed [18:0] WALL_X = 19'sd4096;
	localparam logic signed [18:0] WALL_Y = 19'sd6144;

	// Square root: radicand width, root width and steps per pipeline stage.
	localparam int SQ_W          = 34;
	localparam int ROOT_W        = SQ_W / 2;
	localparam int REM_W         = ROOT_W + 2;
	localparam int SQRT_STEPS_HI = 6;
	localparam int SQRT_STEPS_LO = ROOT_W - 2 * SQRT_STEPS_HI;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic        [11:0] time_step;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic        [14:0] glow;
		logic        [12:0] diameter;
	} in_t;

	// State after the Euler step, before the walls.
	typedef struct packed {
		logic signed [17:0] px;
		logic signed [17:0] py;
		logic signed [17:0] vx;
		logic signed [17:0] vy;
		logic        [14:0] glow;
		logic        [11:0] half;
	} kin_t;

	// Finished fields that wait for the speed.
	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic        [14:0] glow;
		logic               hit_x;
		logic               hit_y;
	} side_t;

	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end
		if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

[src/particle_bounce_update.sv]
// Particle bounce update: nine-stage pipeline, one particle word per cycle.
// done is the valid bit of stage nine, which an accepted word reaches through stages one to eight.
// Throughput: one word every cycle; busy is always low and nothing stalls, so
// the receiver must take every result in its strobe cycle; the block does not enforce this.
// Reset clears all valid bits and sets accel_x = 0, accel_y = 0, time_step = 123.
// The depth is set by the 17-step square root for the speed, spread over three stages.
`include "particle_bounce_update_assert.svh"

module particle_bounce_update (
	input  logic               clk,
	input  logic               arst_n,
	// Command side: a word is accepted when start is high and busy is low.
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic        [14:0] glow,
	input  logic        [12:0] diameter,
	// Result side: one word per done strobe.
	output logic               done,
	output logic signed [15:0] new_pos_x,
	output logic signed [15:0] new_pos_y,
	output logic signed [15:0] new_vel_x,
	output logic signed [15:0] new_vel_y,
	output logic        [14:0] new_glow,
	output logic               hit_x,
	output logic               hit_y,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [15:0] cfg_data
);

	localparam int LAT_S1_TO_OUT = 8;

	pbu_pkg::cfg_t  cfg_q;
	logic           in_valid;
	pbu_pkg::in_t   in_word;

	logic           v_s2;
	pbu_pkg::kin_t  kin_s2;

	logic                     v_s4;
	logic [pbu_pkg::SQ_W-1:0] sq_s4;
	pbu_pkg::side_t           side_s4;

	pbu_pkg::sqrt_t sqrt_s4, sqrt_s5, sqrt_s6, sqrt_s7;
	logic           v_s5, v_s6, v_s7;
	pbu_pkg::side_t side_s5, side_s6, side_s7;

	logic           v_s8;
	logic    [30:0] prod_s8;
	pbu_pkg::side_t side_s8;

	logic    [30:0] mag_c;

	logic           v_s9;
	pbu_pkg::side_t out_s9;

	// The pipeline never holds back, so the block is never busy and the
	// configuration port always takes a write.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign in_valid  = start && !busy;

	// Configuration registers. Writes to the unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_x   <= '0;
			cfg_q.accel_y   <= '0;
			cfg_q.time_step <= pbu_pkg::TIME_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbu_pkg::REG_ACCEL_X: begin
					cfg_q.accel_x <= cfg_data;
				end
				pbu_pkg::REG_ACCEL_Y: begin
					cfg_q.accel_y <= cfg_data;
				end
				pbu_pkg::REG_TIME_STEP: begin
					cfg_q.time_step <= cfg_data[11:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_word.pos_x    = pos_x;
	assign in_word.pos_y    = pos_y;
	assign in_word.vel_x    = vel_x;
	assign in_word.vel_y    = vel_y;
	assign in_word.glow     = glow;
	assign in_word.diameter = diameter;

	// Stages one and two: products with the time step, then the Euler update.
	pbu_kin u_kin (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_word   (in_word),
		.out_valid (v_s2),
		.out_word  (kin_s2)
	);

	// Stages three and four: squared speed, wall tests, clamps and bounce velocity.
	pbu_wall u_wall (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_word   (kin_s2),
		.out_valid (v_s4),
		.out_sq    (sq_s4),
		.out_side  (side_s4)
	);

	// Stages five to seven: the square root, six, six and five steps.
	assign sqrt_s4.rad  = sq_s4;
	assign sqrt_s4.rem  = '0;
	assign sqrt_s4.root = '0;

	pbu_sqrt_stage #(.STEPS(pbu_pkg::SQRT_STEPS_HI)) u_sqrt_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_word   (sqrt_s4),
		.out_valid (v_s5),
		.out_word  (sqrt_s5)
	);

	pbu_sqrt_stage #(.STEPS(pbu_pkg::SQRT_STEPS_HI)) u_sqrt_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_word   (sqrt_s5),
		.out_valid (v_s6),
		.out_word  (sqrt_s6)
	);

	pbu_sqrt_stage #(.STEPS(pbu_pkg::SQRT_STEPS_LO)) u_sqrt_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_word   (sqrt_s6),
		.out_valid (v_s7),
		.out_word  (sqrt_s7)
	);

	// The finished fields ride alongside the square root until the speed is known.
	always_ff @(posedge clk) begin
		if (v_s4) begin
			side_s5 <= side_s4;
		end
		if (v_s5) begin
			side_s6 <= side_s5;
		end
		if (v_s6) begin
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage eight: speed times 0.15 in Q0.16.
	always_ff @(posedge clk) begin
		if (v_s7) begin
			prod_s8 <= sqrt_s7.root * pbu_pkg::K_GLOW;
			side_s8 <= side_s7;
		end
	end

	// Stage nine: round the glow product. A hit on either axis replaces the
	// decayed intensity with the speed-based one; both values already fit 15 bits.
	assign mag_c = (prod_s8 + 31'd32768) >> 16;

	always_ff @(posedge clk) begin
		if (v_s8) begin
			out_s9 <= side_s8;
			if (side_s8.hit_x || side_s8.hit_y) begin
				out_s9.glow <= mag_c[14:0];
			end
		end
	end

	assign done      = v_s9;
	assign new_pos_x = out_s9.pos_x;
	assign new_pos_y = out_s9.pos_y;
	assign new_vel_x = out_s9.vel_x;
	assign new_vel_y = out_s9.vel_y;
	assign new_glow  = out_s9.glow;
	assign hit_x     = out_s9.hit_x;
	assign hit_y     = out_s9.hit_y;

	// Every accepted word enters the first stage on the next edge.
	`PBU_ASSERT_NEXT(a_accept_enters, in_valid, u_kin.v_s1 == 1'b1, "accepted word lost")
	// A word in stage one reaches the result ports and raises done.
	`PBU_ASSERT_LATER(a_latency, u_kin.v_s1, LAT_S1_TO_OUT, done, "result strobe missing")
	// A side wall hit leaves the particle inside the side walls.
	`PBU_ASSERT_SAME(a_clamp_x, done && hit_x, new_pos_x <= 16'sd4096 && new_pos_x >= -16'sd4096, "x clamp")
	// Without a hit the intensity only decays, so it stays below 0.9 of full scale.
	`PBU_ASSERT_SAME(a_decay, done && !hit_x && !hit_y, new_glow <= 15'd29491, "glow did not decay")

endmodule

[src/pbu_kin.sv]
// Stages one and two: time step products, then the Euler update of position,
// velocity and intensity. Depends on pbu_pkg.
module pbu_kin (
	input  logic           clk,
	input  logic           arst_n,
	input  pbu_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  pbu_pkg::in_t   in_word,
	output logic           out_valid,
	output pbu_pkg::kin_t  out_word
);

	logic signed [12:0] ts;
	logic signed [28:0] pvx_c, pvy_c, pax_c, pay_c;
	logic        [30:0] pg_c;

	logic               v_s1;
	logic signed [15:0] px_s1, py_s1, vx_s1, vy_s1;
	logic        [11:0] half_s1;
	logic signed [28:0] pvx_s1, pvy_s1, pax_s1, pay_s1;
	logic        [30:0] pg_s1;

	logic signed [28:0] rvx, rvy, rax, ray;
	logic        [30:0] rg;

	logic               v_s2;
	pbu_pkg::kin_t      kin_s2;

	assign ts    = $signed({1'b0, cfg.time_step});
	assign pvx_c = in_word.vel_x * ts;
	assign pvy_c = in_word.vel_y * ts;
	assign pax_c = cfg.accel_x * ts;
	assign pay_c = cfg.accel_y * ts;
	assign pg_c  = in_word.glow * pbu_pkg::K_DECAY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			px_s1   <= in_word.pos_x;
			py_s1   <= in_word.pos_y;
			vx_s1   <= in_word.vel_x;
			vy_s1   <= in_word.vel_y;
			half_s1 <= in_word.diameter[12:1];
			pvx_s1  <= pvx_c;
			pvy_s1  <= pvy_c;
			pax_s1  <= pax_c;
			pay_s1  <= pay_c;
			pg_s1   <= pg_c;
		end
	end

	// Round to nearest with ties upward: add half an LSB, then shift arithmetically.
	always_comb begin
		rvx = (pvx_s1 + 29'sd2048) >>> 12;
		rvy = (pvy_s1 + 29'sd2048) >>> 12;
		rax = (pax_s1 + 29'sd2048) >>> 12;
		ray = (pay_s1 + 29'sd2048) >>> 12;
		rg  = (pg_s1 + 31'd32768) >> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kin_s2.px   <= {{2{px_s1[15]}}, px_s1} + {rvx[16], rvx[16:0]};
			kin_s2.py   <= {{2{py_s1[15]}}, py_s1} + {rvy[16], rvy[16:0]};
			kin_s2.vx   <= {{2{vx_s1[15]}}, vx_s1} + {rax[16], rax[16:0]};
			kin_s2.vy   <= {{2{vy_s1[15]}}, vy_s1} + {ray[16], ray[16:0]};
			kin_s2.glow <= rg[14:0];
			kin_s2.half <= half_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_word  = kin_s2;

endmodule

[src/pbu_wall.sv]
// Stages three and four: squares for the speed, wall tests and clamps, and the
// damped bounce velocity. Depends on pbu_pkg.
module pbu_wall (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  pbu_pkg::kin_t              in_word,
	output logic                       out_valid,
	output logic [pbu_pkg::SQ_W-1:0]   out_sq,
	output pbu_pkg::side_t             out_side
);

	logic signed [17:0] half18;
	logic signed [18:0] x_hi, x_lo, y_hi, y_lo;
	logic               x_hit_hi, x_hit_lo, y_hit_hi, y_hit_lo;
	logic signed [18:0] px_c, py_c;
	logic signed [35:0] sqx_c, sqy_c, dmx_c, dmy_c;
	logic signed [17:0] kdamp;

	logic               v_s3;
	logic        [32:0] sqx_s3, sqy_s3;
	logic signed [35:0] dmx_s3, dmy_s3;
	logic signed [17:0] px_s3, py_s3, vx_s3, vy_s3;
	logic        [14:0] glow_s3;
	logic               hx_s3, hy_s3;

	logic signed [35:0] rdx, rdy;
	logic signed [17:0] nvx, nvy;

	logic                     v_s4;
	logic [pbu_pkg::SQ_W-1:0] sq_s4;
	pbu_pkg::side_t           side_s4;

	assign half18 = $signed({6'b0, in_word.half});
	assign kdamp  = $signed({1'b0, pbu_pkg::K_DAMP});

	always_comb begin
		x_hi = {in_word.px[17], in_word.px} + {half18[17], half18};
		x_lo = {in_word.px[17], in_word.px} - {half18[17], half18};
		y_hi = {in_word.py[17], in_word.py} + {half18[17], half18};
		y_lo = {in_word.py[17], in_word.py} - {half18[17], half18};
		x_hit_hi = x_hi > pbu_pkg::WALL_X;
		x_hit_lo = x_lo < -pbu_pkg::WALL_X;
		y_hit_hi = y_hi > pbu_pkg::WALL_Y;
		y_hit_lo = y_lo < -pbu_pkg::WALL_Y;
		// The positive wall is tested first and wins when the particle spans the box.
		if (x_hit_hi) begin
			px_c = pbu_pkg::WALL_X - {half18[17], half18};
		end else if (x_hit_lo) begin
			px_c = {half18[17], half18} - pbu_pkg::WALL_X;
		end else begin
			px_c = {in_word.px[17], in_word.px};
		end
		if (y_hit_hi) begin
			py_c = pbu_pkg::WALL_Y - {half18[17], half18};
		end else if (y_hit_lo) begin
			py_c = {half18[17], half18} - pbu_pkg::WALL_Y;
		end else begin
			py_c = {in_word.py[17], in_word.py};
		end
	end

	assign sqx_c = in_word.vx * in_word.vx;
	assign sqy_c = in_word.vy * in_word.vy;
	assign dmx_c = in_word.vx * kdamp;
	assign dmy_c = in_word.vy * kdamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sqx_s3  <= sqx_c[32:0];
			sqy_s3  <= sqy_c[32:0];
			dmx_s3  <= dmx_c;
			dmy_s3  <= dmy_c;
			px_s3   <= px_c[17:0];
			py_s3   <= py_c[17:0];
			vx_s3   <= in_word.vx;
			vy_s3   <= in_word.vy;
			glow_s3 <= in_word.glow;
			hx_s3   <= x_hit_hi | x_hit_lo;
			hy_s3   <= y_hit_hi | y_hit_lo;
		end
	end

	always_comb begin
		rdx = (dmx_s3 + 36'sd32768) >>> 16;
		rdy = (dmy_s3 + 36'sd32768) >>> 16;
		nvx = hx_s3 ? -rdx[17:0] : vx_s3;
		nvy = hy_s3 ? -rdy[17:0] : vy_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			sq_s4         <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
			side_s4.pos_x <= pbu_pkg::sat16(px_s3);
			side_s4.pos_y <= pbu_pkg::sat16(py_s3);
			side_s4.vel_x <= pbu_pkg::sat16(nvx);
			side_s4.vel_y <= pbu_pkg::sat16(nvy);
			side_s4.glow  <= glow_s3;
			side_s4.hit_x <= hx_s3;
			side_s4.hit_y <= hy_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_sq    = sq_s4;
	assign out_side  = side_s4;

endmodule

[src/pbu_sqrt_stage.sv]
// One register stage of the digit-by-digit integer square root, STEPS
// radicand bit pairs per stage. Depends on pbu_pkg.
module pbu_sqrt_stage #(
	parameter int STEPS = pbu_pkg::SQRT_STEPS_HI
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  pbu_pkg::sqrt_t  in_word,
	output logic            out_valid,
	output pbu_pkg::sqrt_t  out_word
);

	localparam int ACC_W = pbu_pkg::REM_W + 2;

	pbu_pkg::sqrt_t   w;
	logic [ACC_W-1:0] acc;
	logic [ACC_W-1:0] trial;

	logic             v_sn;
	pbu_pkg::sqrt_t   res_sn;

	// Each step brings down two radicand bits and tries the next root bit.
	always_comb begin
		w     = in_word;
		acc   = '0;
		trial = '0;
		for (int i = 0; i < STEPS; i++) begin
			acc   = {w.rem, w.rad[pbu_pkg::SQ_W-1 -: 2]};
			trial = {2'b00, w.root, 2'b01};
			w.rad = {w.rad[pbu_pkg::SQ_W-3:0], 2'b00};
			if (acc >= trial) begin
				w.rem  = pbu_pkg::REM_W'(acc - trial);
				w.root = {w.root[pbu_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				w.rem  = acc[pbu_pkg::REM_W-1:0];
				w.root = {w.root[pbu_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else begin
			v_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			res_sn <= w;
		end
	end

	assign out_valid = v_sn;
	assign out_word  = res_sn;

endmodule
